// ===== sv/afuf_pkg.sv =====
// ----------------------------------------------------------------------------
// afuf_pkg: shared types and constants for the audio fifo underrun fade unit
// Sample width, store geometry, fade length, beat structs and source codes.
// ----------------------------------------------------------------------------
package afuf_pkg;

  // sample and store geometry
  localparam int SAMPLE_W   = 16;
  localparam int ADDR_W     = 12;
  localparam int DEPTH      = 1 << ADDR_W;
  localparam int FILL_W     = 12;

  // fade ramp length, a power of two so the divide is a shift
  localparam int FADE_SHIFT = 8;
  localparam int FADE_LEN   = 1 << FADE_SHIFT;
  localparam int POS_W      = FADE_SHIFT + 1;

  // product of a sample and a ramp factor
  localparam int PROD_W     = SAMPLE_W + POS_W + 1;

  // request kinds
  localparam logic KIND_PUSH  = 1'b0;
  localparam logic KIND_FRAME = 1'b1;

  // where a response frame comes from
  typedef enum logic [1:0] {
    SRC_DATA      = 2'd0,
    SRC_FADE      = 2'd1,
    SRC_SILENCE   = 2'd2,
    SRC_WRITE_ACK = 2'd3
  } src_t;

  // request beat
  typedef struct packed {
    logic                       kind;
    logic signed [SAMPLE_W-1:0] write_sample;
  } req_t;

  // response beat
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
    src_t                       frame_source;
    logic                       write_accepted;
    logic [FILL_W-1:0]          fill_level;
  } rsp_t;

  // decision handed from the pointer stage to the output stage
  typedef struct packed {
    src_t              source;
    logic              pop_two;
    logic              accepted;
    logic [POS_W-1:0]  factor;
    logic [FILL_W-1:0] fill;
  } stage_t;

endpackage

// ===== sv/afuf_ram.sv =====
// ----------------------------------------------------------------------------
// afuf_ram: generic sample ram
// One write port, two read ports, registered read data, no reset.
// ----------------------------------------------------------------------------
module afuf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_a,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // two registered read ports
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

// ===== sv/afuf_ctrl.sv =====
// ----------------------------------------------------------------------------
// afuf_ctrl: pointer and fade control stage
// Owns the ring pointers and the fade position, decides each beat's outcome,
// drives the ram write and the two read addresses at accept.
// ----------------------------------------------------------------------------
module afuf_ctrl import afuf_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  req_t                       req,
  output logic                       wr_en,
  output logic [ADDR_W-1:0]          wr_addr,
  output logic [SAMPLE_W-1:0]        wr_data,
  output logic [ADDR_W-1:0]          rd_addr_a,
  output logic [ADDR_W-1:0]          rd_addr_b,
  output stage_t                     stage
);

  logic [ADDR_W-1:0] wr_ptr;
  logic [ADDR_W-1:0] wr_ptr_next;
  logic [ADDR_W-1:0] rd_ptr;
  logic [ADDR_W-1:0] rd_ptr_next;
  logic [POS_W-1:0]  pos;
  logic [POS_W-1:0]  pos_next;
  logic [ADDR_W-1:0] fill;
  logic              full;

  // occupancy from the pointers
  assign fill = wr_ptr - rd_ptr;
  assign full = (fill == ADDR_W'(DEPTH - 1));

  // ram addressing
  assign wr_addr   = wr_ptr;
  assign wr_data   = req.write_sample;
  assign rd_addr_a = rd_ptr;
  assign rd_addr_b = rd_ptr + ADDR_W'(1);
  assign wr_en     = accept && (req.kind == KIND_PUSH) && !full;

  // decide the outcome of the beat
  always_comb begin
    wr_ptr_next    = wr_ptr;
    rd_ptr_next    = rd_ptr;
    pos_next       = pos;
    stage.source   = SRC_WRITE_ACK;
    stage.pop_two  = 1'b0;
    stage.accepted = 1'b0;
    stage.factor   = POS_W'(FADE_LEN) - pos;
    if (req.kind == KIND_PUSH) begin
      if (!full) begin
        wr_ptr_next    = wr_ptr + ADDR_W'(1);
        stage.accepted = 1'b1;
      end
    end else begin
      priority if (fill >= ADDR_W'(2)) begin
        rd_ptr_next   = rd_ptr + ADDR_W'(2);
        pos_next      = '0;
        stage.source  = SRC_DATA;
        stage.pop_two = 1'b1;
      end else if (fill == ADDR_W'(1)) begin
        rd_ptr_next   = rd_ptr + ADDR_W'(1);
        pos_next      = '0;
        stage.source  = SRC_DATA;
      end else if (pos < POS_W'(FADE_LEN)) begin
        pos_next      = pos + POS_W'(1);
        stage.source  = SRC_FADE;
      end else begin
        stage.source  = SRC_SILENCE;
      end
    end
    stage.fill = FILL_W'(wr_ptr_next - rd_ptr_next);
  end

  // pointer and fade registers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      pos    <= '0;
    end else if (accept) begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      pos    <= pos_next;
    end
  end

  // fade position stays within the ramp
  assert property (@(posedge clk) disable iff (rst) pos <= POS_W'(FADE_LEN))
    else $error("fade position beyond ramp length");

  // a frame with two samples held moves the read pointer by two
  assert property (@(posedge clk) disable iff (rst)
    accept && req.kind == KIND_FRAME && fill >= ADDR_W'(2)
    |=> rd_ptr == ADDR_W'($past(rd_ptr) + ADDR_W'(2)))
    else $error("read pointer did not advance by two");

  // never store into a full ring
  assert property (@(posedge clk) disable iff (rst) wr_en |-> !full)
    else $error("write into full ring");

endmodule

// ===== sv/afuf_out.sv =====
// ----------------------------------------------------------------------------
// afuf_out: sample stage and response register
// Takes the ram read data and the stage decision, keeps the held frame,
// forms the fade ramp and drives the response beat.
// ----------------------------------------------------------------------------
module afuf_out import afuf_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  stage_t              stage,
  input  logic [SAMPLE_W-1:0] rd_data_a,
  input  logic [SAMPLE_W-1:0] rd_data_b,
  output logic                busy,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output rsp_t                rsp
);

  logic                       s1_valid;
  stage_t                     s1;
  logic                       move;
  logic signed [SAMPLE_W-1:0] held_left;
  logic signed [SAMPLE_W-1:0] held_right;
  logic signed [PROD_W-1:0]   prod_left;
  logic signed [PROD_W-1:0]   prod_right;
  logic signed [PROD_W-1:0]   fac;
  logic signed [SAMPLE_W-1:0] ramp_left;
  logic signed [SAMPLE_W-1:0] ramp_right;
  rsp_t                       rsp_next;

  // stage handshake
  assign move = s1_valid && (!rsp_valid || !rsp_stall);
  assign busy = s1_valid && !move;

  // ramp: held times factor, divided by the ramp length toward zero
  assign fac        = PROD_W'($signed({1'b0, s1.factor}));
  assign prod_left  = PROD_W'(held_left) * fac;
  assign prod_right = PROD_W'(held_right) * fac;
  assign ramp_left  = SAMPLE_W'((prod_left + (prod_left[PROD_W-1] ?
                      PROD_W'(FADE_LEN - 1) : PROD_W'(0))) >>> FADE_SHIFT);
  assign ramp_right = SAMPLE_W'((prod_right + (prod_right[PROD_W-1] ?
                      PROD_W'(FADE_LEN - 1) : PROD_W'(0))) >>> FADE_SHIFT);

  // response payload
  always_comb begin
    rsp_next.frame_source   = s1.source;
    rsp_next.write_accepted = s1.accepted;
    rsp_next.fill_level     = s1.fill;
    rsp_next.left_sample    = '0;
    rsp_next.right_sample   = '0;
    unique case (s1.source)
      SRC_DATA: begin
        rsp_next.left_sample  = rd_data_a;
        rsp_next.right_sample = s1.pop_two ? rd_data_b : '0;
      end
      SRC_FADE: begin
        rsp_next.left_sample  = ramp_left;
        rsp_next.right_sample = ramp_right;
      end
      SRC_SILENCE, SRC_WRITE_ACK: begin
        rsp_next.left_sample  = '0;
        rsp_next.right_sample = '0;
      end
      default: begin
        rsp_next.left_sample  = '0;
        rsp_next.right_sample = '0;
      end
    endcase
  end

  // stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (move) begin
        s1_valid <= 1'b0;
      end
      if (move) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // stage and response payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= stage;
    end
    if (move) begin
      rsp <= rsp_next;
    end
  end

  // held frame, updated when a full frame leaves the stage
  always_ff @(posedge clk) begin
    if (rst) begin
      held_left  <= '0;
      held_right <= '0;
    end else if (move && s1.source == SRC_DATA && s1.pop_two) begin
      held_left  <= rd_data_a;
      held_right <= rd_data_b;
    end
  end

  // silence and write beats carry no samples
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.frame_source == SRC_SILENCE ||
                  rsp.frame_source == SRC_WRITE_ACK)
    |-> rsp.left_sample == '0 && rsp.right_sample == '0)
    else $error("nonzero samples on silence or write beat");

  // only write beats report a stored sample
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.write_accepted |-> rsp.frame_source == SRC_WRITE_ACK)
    else $error("write accepted on a frame beat");

  // a new beat is only taken when the stage can hand its content on
  assert property (@(posedge clk) disable iff (rst)
    accept |-> !s1_valid || move)
    else $error("stage overwritten");

endmodule

// ===== sv/audio_fifo_underrun_fade_unit.sv =====
// ----------------------------------------------------------------------------
// audio_fifo_underrun_fade_unit: stereo sample ring with underrun fade-out
// Pushes single samples into a ring ram, pops stereo frames, and ramps the
// last frame to silence when the ring runs dry.
//
//   channel | signals                     | beat
//   --------+-----------------------------+---------------------------------
//   request | req_valid, req_stall, req   | push one sample or ask a frame
//   response| rsp_valid, rsp_stall, rsp   | one frame or write ack per beat
//
// One request beat per cycle is sustained while rsp_stall stays low; the ram read
// and the stage register load at accept, then the response register loads once
// the stage can hand its content on.
// rst is synchronous: pointers, fade position and held frame clear at once,
// no clearing pass; the ram contents stay undefined until written.
// req_stall rises only when the stage and the response register are full
// and rsp_stall is high.
// ----------------------------------------------------------------------------
module audio_fifo_underrun_fade_unit import afuf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  logic                accept;
  logic                busy;
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic [SAMPLE_W-1:0] wr_data;
  logic [ADDR_W-1:0]   rd_addr_a;
  logic [ADDR_W-1:0]   rd_addr_b;
  logic [SAMPLE_W-1:0] rd_data_a;
  logic [SAMPLE_W-1:0] rd_data_b;
  stage_t              stage;

  // request handshake
  assign req_stall = busy;
  assign accept    = req_valid && !busy;

  // pointer and fade control
  afuf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .req       (req),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .stage     (stage)
  );

  // sample ring storage
  afuf_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (accept),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  // output stage
  afuf_out u_out (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .stage     (stage),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b),
    .busy      (busy),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

// ===== tb/tb_audio_fifo_underrun_fade_unit.sv =====
// ----------------------------------------------------------------------------
// tb_audio_fifo_underrun_fade_unit: self-checking bench for the stereo ring
// Drives push and frame beats under random and long-stretch backpressure,
// predicts every response from a local model of the ring, the held frame and
// the fade ramp, and compares each response beat field by field.
// ----------------------------------------------------------------------------
module tb_audio_fifo_underrun_fade_unit import afuf_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // cycles without any accepted beat before the run is called hung
  localparam int QUIET_LIMIT = 4000;
  // receiver hold-off used to back the block up
  localparam int LONG_HOLD   = 400;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  // idle rates in percent, and a pending long hold for the receiver
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int rsp_hold_left = 0;
  int fail_count    = 0;

  // model state of the ring and the fade
  logic signed [SAMPLE_W-1:0] ring_store [DEPTH];
  logic [ADDR_W-1:0]          ring_wr_ptr = '0;
  logic [ADDR_W-1:0]          ring_rd_ptr = '0;
  logic signed [SAMPLE_W-1:0] last_left   = '0;
  logic signed [SAMPLE_W-1:0] last_right  = '0;
  logic [POS_W-1:0]           ramp_pos    = '0;

  // responses predicted but not yet seen
  rsp_t frame_expect [$];

  audio_fifo_underrun_fade_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // 10 ns clock
  initial begin
    forever #5 clk = ~clk;
  end

  // linear ramp of a held sample, truncated toward zero
  function automatic logic signed [SAMPLE_W-1:0] fade_of(input logic signed [SAMPLE_W-1:0] held);
    int prod;
    prod = int'(held) * (FADE_LEN - int'(ramp_pos));
    return SAMPLE_W'(prod / FADE_LEN);
  endfunction

  // advance the ring model by one request beat and give its response
  function automatic rsp_t ring_model(input req_t beat);
    rsp_t              r;
    logic [ADDR_W-1:0] fill;
    logic [ADDR_W-1:0] next_rd;
    r = '0;
    fill = ring_wr_ptr - ring_rd_ptr;
    next_rd = ring_rd_ptr + ADDR_W'(1);
    if (beat.kind == KIND_PUSH) begin
      r.frame_source = SRC_WRITE_ACK;
      if (fill < DEPTH - 1) begin
        ring_store[ring_wr_ptr] = beat.write_sample;
        ring_wr_ptr = ring_wr_ptr + ADDR_W'(1);
        r.write_accepted = 1'b1;
      end
    end else if (fill >= 2) begin
      r.left_sample  = ring_store[ring_rd_ptr];
      r.right_sample = ring_store[next_rd];
      ring_rd_ptr = next_rd + ADDR_W'(1);
      last_left  = r.left_sample;
      last_right = r.right_sample;
      ramp_pos = '0;
      r.frame_source = SRC_DATA;
    end else if (fill == 1) begin
      // lone sample goes out as left, held frame untouched
      r.left_sample = ring_store[ring_rd_ptr];
      ring_rd_ptr = next_rd;
      ramp_pos = '0;
      r.frame_source = SRC_DATA;
    end else if (ramp_pos < FADE_LEN) begin
      r.left_sample  = fade_of(last_left);
      r.right_sample = fade_of(last_right);
      ramp_pos = ramp_pos + POS_W'(1);
      r.frame_source = SRC_FADE;
    end else begin
      r.frame_source = SRC_SILENCE;
    end
    r.fill_level = ring_wr_ptr - ring_rd_ptr;
    return r;
  endfunction

  // offer one request beat, with random gaps, and predict it once accepted
  task automatic send_beat(input logic kind, input logic signed [SAMPLE_W-1:0] sample);
    req_t beat;
    beat.kind = kind;
    beat.write_sample = sample;
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= beat;
    do @(posedge clk); while (req_stall);
    frame_expect.push_back(ring_model(beat));
  endtask

  task automatic push_sample(input logic signed [SAMPLE_W-1:0] sample);
    send_beat(KIND_PUSH, sample);
  endtask

  // the sample field is don't-care on frame requests, so fill it with noise
  task automatic ask_frame();
    send_beat(KIND_FRAME, SAMPLE_W'($urandom));
  endtask

  // stop offering and wait until every predicted response has arrived
  task automatic wait_for_results();
    req_valid <= 1'b0;
    while (frame_expect.size() != 0) @(posedge clk);
  endtask

  task automatic set_idle(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // extremes of the sample, pairs, a lone sample, and ramp rounding
  task automatic test_directed_edges();
    ask_frame();
    push_sample(-16'sd32768);
    push_sample(16'sd32767);
    ask_frame();
    ask_frame();
    ask_frame();
    push_sample(16'sh5555);
    push_sample(16'shAAAA);
    push_sample(16'sd0);
    ask_frame();
    ask_frame();
    ask_frame();
    push_sample(-16'sd1);
    push_sample(16'sd1);
    ask_frame();
    ask_frame();
    ask_frame();
    push_sample(16'sd255);
    push_sample(-16'sd255);
    ask_frame();
    ask_frame();
    ask_frame();
    ask_frame();
    wait_for_results();
  endtask

  // full ramp down to silence, then a lone sample and a restarted ramp
  task automatic test_fade_out();
    push_sample(16'sd32767);
    push_sample(-16'sd32767);
    ask_frame();
    repeat (FADE_LEN + 3) ask_frame();
    push_sample(SAMPLE_W'($urandom));
    ask_frame();
    repeat (4) ask_frame();
    push_sample(-16'sd3);
    push_sample(16'sd7);
    push_sample(16'sd9);
    ask_frame();
    ask_frame();
    repeat (FADE_LEN + 2) ask_frame();
    wait_for_results();
  endtask

  // receiver holds off long while the sender keeps offering beats
  task automatic test_backpressure_hold();
    rsp_hold_left = LONG_HOLD;
    for (int i = 0; i < 24; i++) begin
      if (i % 3 == 2) ask_frame();
      else push_sample(SAMPLE_W'($urandom));
    end
    repeat (10) ask_frame();
    wait_for_results();
  endtask

  // bursts leaning toward pushes or frames, with occasional long dry spells
  task automatic test_random_traffic(input int n_items);
    int sent;
    int mode;
    int burst;
    int pick;
    sent = 0;
    while (sent < n_items) begin
      mode = $urandom_range(11);
      if (mode == 0) begin
        repeat (FADE_LEN + 8) ask_frame();
        sent += FADE_LEN + 8;
      end else begin
        burst = $urandom_range(40, 1);
        for (int i = 0; i < burst; i++) begin
          pick = $urandom_range(99);
          if (mode < 4) begin
            if (pick < 80) push_sample(SAMPLE_W'($urandom));
            else ask_frame();
          end else if (mode < 8) begin
            if (pick < 80) ask_frame();
            else push_sample(SAMPLE_W'($urandom));
          end else begin
            if (pick < 50) push_sample(SAMPLE_W'($urandom));
            else ask_frame();
          end
        end
        sent += burst;
      end
    end
    wait_for_results();
  endtask

  // compare one response beat with its prediction
  task automatic check_frame(input rsp_t got, input rsp_t want);
    if (got.left_sample !== want.left_sample) begin
      $display("%0t left_sample expected %0d got %0d", $time, want.left_sample,
               got.left_sample);
      fail_count++;
    end
    if (got.right_sample !== want.right_sample) begin
      $display("%0t right_sample expected %0d got %0d", $time, want.right_sample,
               got.right_sample);
      fail_count++;
    end
    if (got.frame_source !== want.frame_source) begin
      $display("%0t frame_source expected %0d got %0d", $time, want.frame_source,
               got.frame_source);
      fail_count++;
    end
    if (got.write_accepted !== want.write_accepted) begin
      $display("%0t write_accepted expected %0d got %0d", $time, want.write_accepted,
               got.write_accepted);
      fail_count++;
    end
    if (got.fill_level !== want.fill_level) begin
      $display("%0t fill_level expected %0d got %0d", $time, want.fill_level,
               got.fill_level);
      fail_count++;
    end
  endtask

  // response side: random stalls, or a counted long hold when one is pending
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (rsp_hold_left > 0) begin
        rsp_stall <= 1'b1;
        rsp_hold_left--;
      end else begin
        rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // check every accepted response beat against the oldest prediction
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (frame_expect.size() == 0) begin
        $display("%0t unexpected response beat left %0d right %0d source %0d",
                 $time, rsp.left_sample, rsp.right_sample, rsp.frame_source);
        fail_count++;
      end else begin
        check_frame(rsp, frame_expect.pop_front());
      end
    end
  end

  // hang detector: too long without any beat moving on either channel
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
      else quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // test sequence
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    set_idle(14, 81);
    test_directed_edges();
    test_fade_out();
    test_backpressure_hold();
    test_random_traffic(140);

    set_idle(81, 14);
    test_random_traffic(140);

    set_idle(0, 0);
    test_random_traffic(140);

    wait_for_results();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && frame_expect.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
